[hw/rtl/tbrd_pkg.sv]
// Shared types, constants and the control program of the tremor detector.
package tbrd_pkg;

   // Field and register widths.
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int THR_BITS       = 15;
   localparam int MIN_BITS       = 8;
   localparam int COUNT_BITS     = 16;
   localparam int RUN_BITS       = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Datapath widths.
   localparam int MUL_A_W = 2 * THR_BITS + 1;
   localparam int MUL_B_W = SAMPLE_BITS + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 36;
   localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
   localparam int LIMIT_W = 2 * THR_BITS + COUNT_BITS;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (COEF_FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] Y_MAX_WIDE = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic signed [ACC_W-1:0] Y_MIN_WIDE = -Y_MAX_WIDE - ACC_W'(1);
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = Y_MAX_WIDE[SAMPLE_BITS-1:0];
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = Y_MIN_WIDE[SAMPLE_BITS-1:0];
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [RUN_BITS-1:0]   RUN_MAX   = '1;

   // Register reset values.
   localparam logic signed [COEF_BITS-1:0] RST_COEF_B0 = 16'sd1126;
   localparam logic signed [COEF_BITS-1:0] RST_COEF_A1 = -16'sd26714;
   localparam logic signed [COEF_BITS-1:0] RST_COEF_A2 = 16'sd14131;
   localparam logic [THR_BITS-1:0]         RST_RMS_THR = 15'd410;
   localparam logic [MIN_BITS-1:0]         RST_MIN_SEC = 8'd3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEF_B0       = 3'd0,
      CSR_COEF_A1       = 3'd1,
      CSR_COEF_A2       = 3'd2,
      CSR_RMS_THRESHOLD = 3'd3,
      CSR_MIN_SECONDS   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      MA_B0, MA_A1, MA_A2, MA_THR, MA_THRSQ, MA_YOUT
   } mul_a_sel_type;

   typedef enum logic [2:0] {
      MB_DIFF, MB_YD1, MB_YD2, MB_THR, MB_COUNT, MB_YOUT
   } mul_b_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_SUB
   } acc_op_type;

   typedef enum logic [2:0] {
      C_NEVER, C_ALWAYS, C_NO_REQ, C_TICK, C_MORE_AXES, C_COUNT_ZERO, C_OUT_BUSY
   } cond_type;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'd0,
      ST_DISPATCH = 5'd1,
      ST_MUL_B0   = 5'd2,
      ST_MUL_A1   = 5'd3,
      ST_MUL_A2   = 5'd4,
      ST_ACC_A2   = 5'd5,
      ST_FILT     = 5'd6,
      ST_SQUARE   = 5'd7,
      ST_ENERGY   = 5'd8,
      ST_COUNT    = 5'd9,
      ST_TICK     = 5'd10,
      ST_THR_SQ   = 5'd11,
      ST_LIMIT    = 5'd12,
      ST_JUDGE    = 5'd13,
      ST_EMPTY    = 5'd14,
      ST_EMIT     = 5'd15,
      ST_RETURN   = 5'd16
   } step_type;

   typedef struct packed {
      logic          accept;
      mul_a_sel_type mul_a_sel;
      mul_b_sel_type mul_b_sel;
      logic          mul_en;
      acc_op_type    acc_op;
      logic          filt_wr;
      logic          energy_add;
      logic          axis_step;
      logic          count_inc;
      logic          tick_eval;
      logic          tick_clear;
      logic          emit;
      cond_type      cond;
      step_type      target;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic is_tick;
      logic more_axes;
      logic count_zero;
      logic out_busy;
   } status_type;

   // The control program: one word per step.
   function automatic ctrl_type ctrl_rom(step_type s);
      ctrl_type w;
      w = '0;
      case (s)
         ST_IDLE: begin
            w.accept = 1'b1;
            w.cond   = C_NO_REQ;
            w.target = ST_IDLE;
         end
         ST_DISPATCH: begin
            w.cond   = C_TICK;
            w.target = ST_TICK;
         end
         ST_MUL_B0: begin
            w.mul_a_sel = MA_B0;
            w.mul_b_sel = MB_DIFF;
            w.mul_en    = 1'b1;
         end
         ST_MUL_A1: begin
            w.acc_op    = ACC_LOAD;
            w.mul_a_sel = MA_A1;
            w.mul_b_sel = MB_YD1;
            w.mul_en    = 1'b1;
         end
         ST_MUL_A2: begin
            w.acc_op    = ACC_SUB;
            w.mul_a_sel = MA_A2;
            w.mul_b_sel = MB_YD2;
            w.mul_en    = 1'b1;
         end
         ST_ACC_A2: begin
            w.acc_op = ACC_SUB;
         end
         ST_FILT: begin
            w.filt_wr = 1'b1;
         end
         ST_SQUARE: begin
            w.mul_a_sel = MA_YOUT;
            w.mul_b_sel = MB_YOUT;
            w.mul_en    = 1'b1;
         end
         ST_ENERGY: begin
            w.energy_add = 1'b1;
            w.axis_step  = 1'b1;
            w.cond       = C_MORE_AXES;
            w.target     = ST_MUL_B0;
         end
         ST_COUNT: begin
            w.count_inc = 1'b1;
            w.cond      = C_ALWAYS;
            w.target    = ST_EMIT;
         end
         ST_TICK: begin
            w.cond   = C_COUNT_ZERO;
            w.target = ST_EMPTY;
         end
         ST_THR_SQ: begin
            w.mul_a_sel = MA_THR;
            w.mul_b_sel = MB_THR;
            w.mul_en    = 1'b1;
         end
         ST_LIMIT: begin
            w.mul_a_sel = MA_THRSQ;
            w.mul_b_sel = MB_COUNT;
            w.mul_en    = 1'b1;
         end
         ST_JUDGE: begin
            w.tick_eval = 1'b1;
            w.cond      = C_ALWAYS;
            w.target    = ST_EMIT;
         end
         ST_EMPTY: begin
            w.tick_clear = 1'b1;
         end
         ST_EMIT: begin
            w.emit   = 1'b1;
            w.cond   = C_OUT_BUSY;
            w.target = ST_EMIT;
         end
         ST_RETURN: begin
            w.cond   = C_ALWAYS;
            w.target = ST_IDLE;
         end
         default: begin
            w.cond   = C_ALWAYS;
            w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[hw/rtl/tbrd_if.sv]
// Handshake interfaces for the request, response and register write channels.
interface tbrd_req_if;
   import tbrd_pkg::*;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;
   modport source (output valid, operation, accel_x, accel_y, accel_z, input ready);
   modport sink   (input valid, operation, accel_x, accel_y, accel_z, output ready);
endinterface

interface tbrd_rsp_if;
   import tbrd_pkg::*;
   logic                valid;
   logic                ready;
   logic                tremor_active;
   logic [RUN_BITS-1:0] loud_seconds;
   modport source (output valid, tremor_active, loud_seconds, input ready);
   modport sink   (input valid, tremor_active, loud_seconds, output ready);
endinterface

interface tbrd_csr_if;
   import tbrd_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/tbrd_sequencer.sv]
// Step counter and control store that drive the detector datapath.
module tbrd_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  tbrd_pkg::status_type status,
   output tbrd_pkg::ctrl_type   ctrl
);
   import tbrd_pkg::*;

   step_type pc_ff;
   step_type pc_in;
   logic     jump;

   assign ctrl = ctrl_rom(pc_ff);

   always_comb begin
      case (ctrl.cond)
         C_NEVER:      jump = 1'b0;
         C_ALWAYS:     jump = 1'b1;
         C_NO_REQ:     jump = !status.req_valid;
         C_TICK:       jump = status.is_tick;
         C_MORE_AXES:  jump = status.more_axes;
         C_COUNT_ZERO: jump = status.count_zero;
         C_OUT_BUSY:   jump = status.out_busy;
         default:      jump = 1'b1;
      endcase
      pc_in = jump ? ctrl.target : step_type'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[hw/rtl/tbrd_datapath.sv]
// Shared multiplier, filter accumulator, delay lines, energy and run registers.
module tbrd_datapath #(
   parameter int ENERGY_BITS = 48,
   parameter int AXES        = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tbrd_pkg::ctrl_type                    ctrl,
   input  logic                                  req_valid,
   input  logic                                  req_operation,
   input  logic signed [tbrd_pkg::SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [tbrd_pkg::SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [tbrd_pkg::SAMPLE_BITS-1:0] req_accel_z,
   input  logic                                  csr_valid,
   input  logic [tbrd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tbrd_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic                                  rsp_tremor_active,
   output logic [tbrd_pkg::RUN_BITS-1:0]         rsp_loud_seconds,
   output tbrd_pkg::status_type                  status
);
   import tbrd_pkg::*;

   localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
   localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);
   localparam int CMP_W = (ENERGY_BITS > LIMIT_W) ? ENERGY_BITS : LIMIT_W;

   // Configuration registers.
   logic signed [COEF_BITS-1:0] coef_b0_ff, coef_a1_ff, coef_a2_ff;
   logic [THR_BITS-1:0]         thr_ff;
   logic [MIN_BITS-1:0]         min_sec_ff;

   // Item and filter state.
   logic                          op_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff   [AXES];
   logic signed [SAMPLE_BITS-1:0] xd1_ff [AXES];
   logic signed [SAMPLE_BITS-1:0] xd2_ff [AXES];
   logic signed [SAMPLE_BITS-1:0] yd1_ff [AXES];
   logic signed [SAMPLE_BITS-1:0] yd2_ff [AXES];
   logic signed [SAMPLE_BITS-1:0] req_axis [3];
   logic [AXIS_W-1:0]             axis_ff, axis_in;

   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;
   logic [ENERGY_BITS-1:0]        energy_ff, energy_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic [RUN_BITS-1:0]           run_ff, run_in;
   logic                          latched_ff, latched_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          active_out_ff;
   logic [RUN_BITS-1:0]           loud_out_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [ACC_W-1:0]   rnd, shifted;
   logic [ENERGY_BITS:0]      energy_sum;
   logic [RUN_BITS-1:0]       run_loud;
   logic                      loud;
   logic                      accept;
   logic                      emit_fire;

   assign accept    = ctrl.accept && req_valid;
   assign emit_fire = ctrl.emit && !status.out_busy;

   assign req_axis[0] = req_accel_x;
   assign req_axis[1] = req_accel_y;
   assign req_axis[2] = req_accel_z;

   assign status.req_valid  = req_valid;
   assign status.is_tick    = op_ff;
   assign status.more_axes  = (axis_ff != LAST_AXIS);
   assign status.count_zero = (count_ff == '0);
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tremor_active = active_out_ff;
   assign rsp_loud_seconds  = loud_out_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      case (ctrl.mul_a_sel)
         MA_B0:    mul_a = MUL_A_W'(coef_b0_ff);
         MA_A1:    mul_a = MUL_A_W'(coef_a1_ff);
         MA_A2:    mul_a = MUL_A_W'(coef_a2_ff);
         MA_THR:   mul_a = MUL_A_W'(thr_ff);
         MA_THRSQ: mul_a = MUL_A_W'(prod_ff[2*THR_BITS-1:0]);
         MA_YOUT:  mul_a = MUL_A_W'(y_ff);
         default:  mul_a = '0;
      endcase
      case (ctrl.mul_b_sel)
         MB_DIFF:  mul_b = MUL_B_W'(x_ff[axis_ff]) - MUL_B_W'(xd2_ff[axis_ff]);
         MB_YD1:   mul_b = MUL_B_W'(yd1_ff[axis_ff]);
         MB_YD2:   mul_b = MUL_B_W'(yd2_ff[axis_ff]);
         MB_THR:   mul_b = MUL_B_W'(thr_ff);
         MB_COUNT: mul_b = MUL_B_W'(count_ff);
         MB_YOUT:  mul_b = MUL_B_W'(y_ff);
         default:  mul_b = '0;
      endcase
   end

   always_comb begin
      prod_in = ctrl.mul_en ? mul_a * mul_b : prod_ff;

      case (ctrl.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = $signed(prod_ff[ACC_W-1:0]);
         ACC_SUB:  acc_in = acc_ff - $signed(prod_ff[ACC_W-1:0]);
         default:  acc_in = acc_ff;
      endcase

      // Round half up, floor shift, then clamp to the sample range.
      rnd     = acc_ff + ROUND_HALF;
      shifted = rnd >>> COEF_FRAC_BITS;
      if (shifted > Y_MAX_WIDE) begin
         y_in = SAMPLE_MAX;
      end else if (shifted < Y_MIN_WIDE) begin
         y_in = SAMPLE_MIN;
      end else begin
         y_in = shifted[SAMPLE_BITS-1:0];
      end
      if (!ctrl.filt_wr) begin
         y_in = y_ff;
      end

      axis_in = axis_ff;
      if (accept) begin
         axis_in = '0;
      end else if (ctrl.axis_step) begin
         axis_in = status.more_axes ? axis_ff + 1'b1 : '0;
      end

      energy_sum = {1'b0, energy_ff} + (ENERGY_BITS + 1)'(prod_ff[SQ_W-1:0]);
      loud = CMP_W'(energy_ff) > CMP_W'(prod_ff[LIMIT_W-1:0]);
      run_loud = (run_ff == RUN_MAX) ? run_ff : run_ff + 1'b1;

      energy_in  = energy_ff;
      count_in   = count_ff;
      run_in     = run_ff;
      latched_in = latched_ff;
      if (ctrl.energy_add) begin
         energy_in = energy_sum[ENERGY_BITS] ? '1 : energy_sum[ENERGY_BITS-1:0];
      end
      if (ctrl.count_inc && count_ff != COUNT_MAX) begin
         count_in = count_ff + 1'b1;
      end
      if (ctrl.tick_eval) begin
         run_in     = loud ? run_loud : '0;
         latched_in = (run_in >= min_sec_ff);
         energy_in  = '0;
         count_in   = '0;
      end
      if (ctrl.tick_clear) begin
         run_in     = '0;
         latched_in = 1'b0;
      end

      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= RST_COEF_B0;
         coef_a1_ff <= RST_COEF_A1;
         coef_a2_ff <= RST_COEF_A2;
         thr_ff     <= RST_RMS_THR;
         min_sec_ff <= RST_MIN_SEC;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_COEF_B0:       coef_b0_ff <= $signed(csr_data[COEF_BITS-1:0]);
            CSR_COEF_A1:       coef_a1_ff <= $signed(csr_data[COEF_BITS-1:0]);
            CSR_COEF_A2:       coef_a2_ff <= $signed(csr_data[COEF_BITS-1:0]);
            CSR_RMS_THRESHOLD: thr_ff     <= csr_data[THR_BITS-1:0];
            CSR_MIN_SECONDS:   min_sec_ff <= csr_data[MIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      y_ff    <= y_in;
      if (accept) begin
         op_ff <= req_operation;
         for (int i = 0; i < AXES; i++) begin
            x_ff[i] <= req_axis[i];
         end
      end
      if (emit_fire) begin
         active_out_ff <= latched_ff;
         loud_out_ff   <= run_ff;
      end
   end

   // Filter and detector state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            xd1_ff[i] <= '0;
            xd2_ff[i] <= '0;
            yd1_ff[i] <= '0;
            yd2_ff[i] <= '0;
         end
         axis_ff      <= '0;
         energy_ff    <= '0;
         count_ff     <= '0;
         run_ff       <= '0;
         latched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.filt_wr) begin
            xd2_ff[axis_ff] <= xd1_ff[axis_ff];
            xd1_ff[axis_ff] <= x_ff[axis_ff];
            yd2_ff[axis_ff] <= yd1_ff[axis_ff];
            yd1_ff[axis_ff] <= y_in;
         end
         axis_ff      <= axis_in;
         energy_ff    <= energy_in;
         count_ff     <= count_in;
         run_ff       <= run_in;
         latched_ff   <= latched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/tremor_bandpass_rms_detector_core.sv]
// Top level of the tremor detector: channels, sequencer and datapath.
//
// Requests arrive on req_chan. A sample request (operation = 0) carries three
// accelerometer axes; each axis runs through a band-pass biquad and the squared
// outputs add to a per-second energy sum. A tick request (operation = 1)
// closes the second, compares the energy against threshold squared times the
// sample count and updates the run of loud seconds and the active latch.
// Every request yields exactly one response on rsp_chan with the latch and
// the current run length.
// Registers are written on csr_chan, which is ready whenever reset is low;
// write them only while no request is in flight.
// Control: one request is handled at a time by a microcoded sequencer around a
// single shared multiplier. A sample takes seven steps per axis; its response
// is registered after the last axis, and the next request is taken only after
// the response is emitted. A tick squares the threshold, scales it by the
// sample count and judges the second; an empty second skips these steps and
// only clears the run and the latch.
// A response that is not taken holds in the output register; the sequencer
// waits on its emit step until the register is free, then returns to idle.
// Synchronous reset restores the register defaults and clears all filter,
// energy, count and run state; neither input channel is ready during reset.
module tremor_bandpass_rms_detector_core #(
   parameter int ENERGY_BITS = 48,
   parameter int AXES        = 3
) (
   input logic        clock,
   input logic        reset,
   tbrd_req_if.sink   req_chan,
   tbrd_rsp_if.source rsp_chan,
   tbrd_csr_if.sink   csr_chan
);
   import tbrd_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   // A request is taken only on the idle step of the program, outside reset.
   assign req_chan.ready = ctrl.accept && !reset;
   // Register writes are taken whenever reset is low.
   assign csr_chan.ready = !reset;

   tbrd_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   tbrd_datapath #(
      .ENERGY_BITS (ENERGY_BITS),
      .AXES        (AXES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .req_valid         (req_chan.valid),
      .req_operation     (req_chan.operation),
      .req_accel_x       (req_chan.accel_x),
      .req_accel_y       (req_chan.accel_y),
      .req_accel_z       (req_chan.accel_z),
      .csr_valid         (csr_chan.valid),
      .csr_index         (csr_chan.index),
      .csr_data          (csr_chan.data),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_tremor_active (rsp_chan.tremor_active),
      .rsp_loud_seconds  (rsp_chan.loud_seconds),
      .status            (status)
   );

endmodule
